@@ rtl/bplus_tree_insert_engine_defines.svh @@
// Assertion macros shared by the B+ tree insert engine.
`ifndef BPLUS_TREE_INSERT_ENGINE_DEFINES_SVH
`define BPLUS_TREE_INSERT_ENGINE_DEFINES_SVH
`ifndef SYNTHESIS
`define BPT_ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define BPT_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define BPT_ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg)
`define BPT_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)
`endif
`endif

@@ rtl/bpt_ins_pkg.sv @@
package bpt_ins_pkg;

    localparam int LEAF_NODES     = 127;
    localparam int INTERNAL_NODES = 63;
    localparam int ATTRIBUTES     = 16;
    localparam int LEAF_KEYS      = 3;
    localparam int NODE_KEYS      = 4;
    localparam int HALF           = 2;
    localparam int WALK_DEPTH     = 8;

    localparam int LEAF_AW  = $clog2(LEAF_NODES);
    localparam int NODE_AW  = $clog2(INTERNAL_NODES);
    localparam int WALK_AW  = $clog2(WALK_DEPTH);
    localparam int DEPTH_W  = WALK_AW + 1;

    localparam logic [6:0] LEAF_NONE = 7'h7F;

    // status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NO_IDX = 2'd1;
    localparam logic [1:0] ST_EXISTS = 2'd2;
    localparam logic [1:0] ST_FULL   = 2'd3;

    localparam logic OP_CREATE = 1'b0;
    localparam logic OP_INSERT = 1'b1;

    // controller to datapath commands
    localparam logic [3:0] CMD_IDLE       = 4'd0;
    localparam logic [3:0] CMD_ACCEPT     = 4'd1;
    localparam logic [3:0] CMD_CREATE     = 4'd2;
    localparam logic [3:0] CMD_WALK_INIT  = 4'd3;
    localparam logic [3:0] CMD_NODE_RD    = 4'd4;
    localparam logic [3:0] CMD_NODE_STEP  = 4'd5;
    localparam logic [3:0] CMD_LEAF_RD    = 4'd6;
    localparam logic [3:0] CMD_LEAF_PLACE = 4'd7;
    localparam logic [3:0] CMD_LEAF_SPLIT = 4'd8;
    localparam logic [3:0] CMD_WRITE2     = 4'd9;
    localparam logic [3:0] CMD_NEW_ROOT   = 4'd10;
    localparam logic [3:0] CMD_UP_RD      = 4'd11;
    localparam logic [3:0] CMD_UP_PLACE   = 4'd12;
    localparam logic [3:0] CMD_UP_SPLIT   = 4'd13;
    localparam logic [3:0] CMD_REPORT_OK  = 4'd14;
    localparam logic [3:0] CMD_REPORT_ERR = 4'd15;

    typedef struct packed {
        logic              opcode;
        logic [3:0]        attribute_index;
        logic signed [31:0] key;
        logic [5:0]        record_block;
        logic [4:0]        record_slot;
    } t_item;

    typedef struct packed {
        logic [1:0] status;
        logic [6:0] leaf_node;
        logic [6:0] root_node;
        logic       root_is_leaf;
    } t_result;

    typedef struct packed {
        logic [1:0]                  fill;
        logic [6:0]                  right;
        logic [LEAF_KEYS-1:0][31:0]  keys;
        logic [LEAF_KEYS-1:0][10:0]  recs;
    } t_leaf_row;

    // child pointer: bit 7 marks a leaf, bits 6:0 the node index
    typedef struct packed {
        logic [2:0]                  fill;
        logic [NODE_KEYS-1:0][31:0]  keys;
        logic [NODE_KEYS:0][7:0]     child;
    } t_node_row;

    typedef struct packed {
        logic [3:0] code;
        logic [1:0] status;
    } t_cmd;

    typedef struct packed {
        logic is_create;
        logic attr_ok;
        logic present;
        logic leaf_pool_full;
        logic is_leaf;
        logic leaf_full;
        logic split_ok;
        logic d_zero;
        logic node_full;
    } t_stat;

endpackage

@@ rtl/bpt_ins_ram.sv @@
module bpt_ins_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/bpt_ins_ctrl.sv @@
`include "bplus_tree_insert_engine_defines.svh"

module bpt_ins_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  bpt_ins_pkg::t_stat i_stat,
    output bpt_ins_pkg::t_cmd  o_cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DECODE = 4'd1;
    localparam logic [3:0] S_WALK   = 4'd2;
    localparam logic [3:0] S_NODE   = 4'd3;
    localparam logic [3:0] S_LEAF   = 4'd4;
    localparam logic [3:0] S_SPLIT2 = 4'd5;
    localparam logic [3:0] S_UP     = 4'd6;
    localparam logic [3:0] S_UPN    = 4'd7;
    localparam logic [3:0] S_DONE   = 4'd8;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_comb begin
        n_state       = r_state;
        o_cmd.code    = bpt_ins_pkg::CMD_IDLE;
        o_cmd.status  = bpt_ins_pkg::ST_OK;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.code = bpt_ins_pkg::CMD_ACCEPT;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_IDLE;
                if (!i_stat.attr_ok) begin
                    o_cmd.code   = bpt_ins_pkg::CMD_REPORT_ERR;
                    o_cmd.status = bpt_ins_pkg::ST_NO_IDX;
                end else if (i_stat.is_create) begin
                    if (i_stat.present) begin
                        o_cmd.code   = bpt_ins_pkg::CMD_REPORT_ERR;
                        o_cmd.status = bpt_ins_pkg::ST_EXISTS;
                    end else if (i_stat.leaf_pool_full) begin
                        o_cmd.code   = bpt_ins_pkg::CMD_REPORT_ERR;
                        o_cmd.status = bpt_ins_pkg::ST_FULL;
                    end else begin
                        o_cmd.code = bpt_ins_pkg::CMD_CREATE;
                        n_state    = S_DONE;
                    end
                end else if (!i_stat.present) begin
                    o_cmd.code   = bpt_ins_pkg::CMD_REPORT_ERR;
                    o_cmd.status = bpt_ins_pkg::ST_NO_IDX;
                end else begin
                    o_cmd.code = bpt_ins_pkg::CMD_WALK_INIT;
                    n_state    = S_WALK;
                end
            end
            S_WALK: begin
                if (i_stat.is_leaf) begin
                    o_cmd.code = bpt_ins_pkg::CMD_LEAF_RD;
                    n_state    = S_LEAF;
                end else begin
                    o_cmd.code = bpt_ins_pkg::CMD_NODE_RD;
                    n_state    = S_NODE;
                end
            end
            S_NODE: begin
                o_cmd.code = bpt_ins_pkg::CMD_NODE_STEP;
                n_state    = S_WALK;
            end
            S_LEAF: begin
                if (!i_stat.leaf_full) begin
                    o_cmd.code = bpt_ins_pkg::CMD_LEAF_PLACE;
                    n_state    = S_DONE;
                end else if (!i_stat.split_ok) begin
                    o_cmd.code   = bpt_ins_pkg::CMD_REPORT_ERR;
                    o_cmd.status = bpt_ins_pkg::ST_FULL;
                    n_state      = S_IDLE;
                end else begin
                    o_cmd.code = bpt_ins_pkg::CMD_LEAF_SPLIT;
                    n_state    = S_SPLIT2;
                end
            end
            S_SPLIT2: begin
                o_cmd.code = bpt_ins_pkg::CMD_WRITE2;
                n_state    = S_UP;
            end
            S_UP: begin
                if (i_stat.d_zero) begin
                    o_cmd.code = bpt_ins_pkg::CMD_NEW_ROOT;
                    n_state    = S_DONE;
                end else begin
                    o_cmd.code = bpt_ins_pkg::CMD_UP_RD;
                    n_state    = S_UPN;
                end
            end
            S_UPN: begin
                if (!i_stat.node_full) begin
                    o_cmd.code = bpt_ins_pkg::CMD_UP_PLACE;
                    n_state    = S_DONE;
                end else begin
                    o_cmd.code = bpt_ins_pkg::CMD_UP_SPLIT;
                    n_state    = S_SPLIT2;
                end
            end
            S_DONE: begin
                o_cmd.code = bpt_ins_pkg::CMD_REPORT_OK;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = (r_state != S_IDLE);

    `BPT_ASSERT_NEXT(a_accept_decodes, i_clk, i_rst_n, (r_state == S_IDLE) && start, r_state == S_DECODE, "accepted beat did not move to decode")
    `BPT_ASSERT_NEXT(a_split_climbs, i_clk, i_rst_n, r_state == S_SPLIT2, r_state == S_UP, "second split write did not climb")
    `BPT_ASSERT_NEXT(a_done_idles, i_clk, i_rst_n, r_state == S_DONE, r_state == S_IDLE, "report did not return to idle")

endmodule

@@ rtl/bpt_ins_dp.sv @@
`include "bplus_tree_insert_engine_defines.svh"

module bpt_ins_dp (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  bpt_ins_pkg::t_item    i_item,
    input  bpt_ins_pkg::t_cmd     i_cmd,
    output bpt_ins_pkg::t_stat    o_stat,
    output logic                  o_done,
    output bpt_ins_pkg::t_result  o_result
);

    localparam int LROW_W = $bits(bpt_ins_pkg::t_leaf_row);
    localparam int NROW_W = $bits(bpt_ins_pkg::t_node_row);

    // index table
    logic                    r_present [bpt_ins_pkg::ATTRIBUTES];
    logic [6:0]              r_root    [bpt_ins_pkg::ATTRIBUTES];
    logic                    r_rleaf   [bpt_ins_pkg::ATTRIBUTES];

    bpt_ins_pkg::t_item      r_item;
    logic [6:0]              r_cur;
    logic                    r_isleaf;
    logic [bpt_ins_pkg::DEPTH_W-1:0] r_depth;
    logic [bpt_ins_pkg::DEPTH_W-1:0] r_run;
    logic [bpt_ins_pkg::DEPTH_W-1:0] r_d;
    logic [bpt_ins_pkg::NODE_AW-1:0] r_walk [bpt_ins_pkg::WALK_DEPTH];
    logic [bpt_ins_pkg::NODE_AW-1:0] r_pv;
    logic [31:0]             r_push;
    logic [7:0]              r_left;
    logic [7:0]              r_right;
    logic [6:0]              r_holder;
    logic [7:0]              r_leaves_used;
    logic [6:0]              r_nodes_used;
    bpt_ins_pkg::t_leaf_row  r_pend_leaf;
    bpt_ins_pkg::t_node_row  r_pend_node;
    logic [6:0]              r_pend_addr;
    logic                    r_pend_is_leaf;
    logic                    r_done;
    bpt_ins_pkg::t_result    r_result;

    // memory ports
    logic                             leaf_we;
    logic [bpt_ins_pkg::LEAF_AW-1:0]  leaf_waddr;
    bpt_ins_pkg::t_leaf_row           leaf_wrow;
    logic [bpt_ins_pkg::LEAF_AW-1:0]  leaf_raddr;
    logic [LROW_W-1:0]                leaf_rdata;
    bpt_ins_pkg::t_leaf_row           lq;
    logic                             node_we;
    logic [bpt_ins_pkg::NODE_AW-1:0]  node_waddr;
    bpt_ins_pkg::t_node_row           node_wrow;
    logic [bpt_ins_pkg::NODE_AW-1:0]  node_raddr;
    logic [NROW_W-1:0]                node_rdata;
    bpt_ins_pkg::t_node_row           nq;

    // leaf insertion
    logic [1:0]  lp;
    logic [31:0] lk [bpt_ins_pkg::LEAF_KEYS+1];
    logic [10:0] lr [bpt_ins_pkg::LEAF_KEYS+1];
    bpt_ins_pkg::t_leaf_row lrow_place, lrow_left, lrow_right;

    // walk-down child choice
    logic [2:0]  wi;
    logic [2:0]  wn;
    logic [7:0]  wchild;

    // internal insertion
    logic [2:0]  np;
    logic [2:0]  nn;
    logic [31:0] tk [bpt_ins_pkg::NODE_KEYS+1];
    logic [7:0]  tc [bpt_ins_pkg::NODE_KEYS+2];
    bpt_ins_pkg::t_node_row nrow_place, nrow_left, nrow_right, nrow_root;

    logic [bpt_ins_pkg::DEPTH_W-1:0] need;
    logic [7:0]  nodes_sum;
    logic [bpt_ins_pkg::DEPTH_W-1:0] d_m1;
    logic [10:0] rec_ptr;

    assign lq      = bpt_ins_pkg::t_leaf_row'(leaf_rdata);
    assign nq      = bpt_ins_pkg::t_node_row'(node_rdata);
    assign rec_ptr = {r_item.record_block, r_item.record_slot};
    assign d_m1    = r_d - 1'b1;

    // find slot in leaf and build the four-entry merge
    always_comb begin
        int i;
        int src;
        src = 0;
        lp = '0;
        for (i = 0; i < bpt_ins_pkg::LEAF_KEYS; i++) begin
            if ((2'(i) < lq.fill) && !(r_item.key < $signed(lq.keys[i]))) begin
                lp = lp + 1'b1;
            end
        end
        for (i = 0; i <= bpt_ins_pkg::LEAF_KEYS; i++) begin
            if (i < int'(lp)) begin
                src = (i > bpt_ins_pkg::LEAF_KEYS - 1) ? bpt_ins_pkg::LEAF_KEYS - 1 : i;
                lk[i] = lq.keys[src];
                lr[i] = lq.recs[src];
            end else if (i == int'(lp)) begin
                lk[i] = r_item.key;
                lr[i] = rec_ptr;
            end else begin
                src = (i == 0) ? 0 : i - 1;
                lk[i] = lq.keys[src];
                lr[i] = lq.recs[src];
            end
        end
        lrow_place = lq;
        lrow_place.fill = lq.fill + 1'b1;
        for (i = 0; i < bpt_ins_pkg::LEAF_KEYS; i++) begin
            lrow_place.keys[i] = lk[i];
            lrow_place.recs[i] = lr[i];
        end
        lrow_left  = lq;
        lrow_right = lq;
        lrow_left.fill   = 2'(bpt_ins_pkg::HALF);
        lrow_right.fill  = 2'(bpt_ins_pkg::HALF);
        lrow_left.right  = r_leaves_used[6:0];
        lrow_right.right = lq.right;
        for (i = 0; i < bpt_ins_pkg::HALF; i++) begin
            lrow_left.keys[i]  = lk[i];
            lrow_left.recs[i]  = lr[i];
            lrow_right.keys[i] = lk[i + bpt_ins_pkg::HALF];
            lrow_right.recs[i] = lr[i + bpt_ins_pkg::HALF];
        end
    end

    // pick the child left of the first key above the new key
    always_comb begin
        int i;
        wn = (nq.fill > 3'(bpt_ins_pkg::NODE_KEYS)) ? 3'(bpt_ins_pkg::NODE_KEYS) : nq.fill;
        wi = '0;
        for (i = 0; i < bpt_ins_pkg::NODE_KEYS; i++) begin
            if ((3'(i) < wn) && !(r_item.key < $signed(nq.keys[i]))) begin
                wi = wi + 1'b1;
            end
        end
        wchild = nq.child[wi];
    end

    // place the pushed key and new right child into an internal node
    always_comb begin
        int i;
        int src;
        src = 0;
        nn = (nq.fill > 3'(bpt_ins_pkg::NODE_KEYS)) ? 3'(bpt_ins_pkg::NODE_KEYS) : nq.fill;
        np = '0;
        for (i = 0; i < bpt_ins_pkg::NODE_KEYS; i++) begin
            if ((3'(i) < nn) && !($signed(r_push) < $signed(nq.keys[i]))) begin
                np = np + 1'b1;
            end
        end
        for (i = 0; i <= bpt_ins_pkg::NODE_KEYS; i++) begin
            if (i < int'(np)) begin
                src = (i > bpt_ins_pkg::NODE_KEYS - 1) ? bpt_ins_pkg::NODE_KEYS - 1 : i;
                tk[i] = nq.keys[src];
            end else if (i == int'(np)) begin
                tk[i] = r_push;
            end else begin
                src = (i == 0) ? 0 : i - 1;
                tk[i] = nq.keys[src];
            end
        end
        for (i = 0; i <= bpt_ins_pkg::NODE_KEYS + 1; i++) begin
            if (i <= int'(np)) begin
                src = (i > bpt_ins_pkg::NODE_KEYS) ? bpt_ins_pkg::NODE_KEYS : i;
                tc[i] = nq.child[src];
            end else if (i == int'(np) + 1) begin
                tc[i] = r_right;
            end else begin
                src = (i == 0) ? 0 : i - 1;
                tc[i] = nq.child[src];
            end
        end
        nrow_place = nq;
        nrow_place.fill = nn + 1'b1;
        for (i = 0; i < bpt_ins_pkg::NODE_KEYS; i++) begin
            nrow_place.keys[i] = tk[i];
        end
        for (i = 0; i <= bpt_ins_pkg::NODE_KEYS; i++) begin
            nrow_place.child[i] = tc[i];
        end
        nrow_left  = nq;
        nrow_right = nq;
        nrow_left.fill  = 3'(bpt_ins_pkg::HALF);
        nrow_right.fill = 3'(bpt_ins_pkg::HALF);
        for (i = 0; i < bpt_ins_pkg::HALF; i++) begin
            nrow_left.keys[i]  = tk[i];
            nrow_right.keys[i] = tk[i + bpt_ins_pkg::HALF + 1];
        end
        for (i = 0; i <= bpt_ins_pkg::HALF; i++) begin
            nrow_left.child[i]  = tc[i];
            nrow_right.child[i] = tc[i + bpt_ins_pkg::HALF + 1];
        end
        nrow_root          = '0;
        nrow_root.fill     = 3'd1;
        nrow_root.keys[0]  = r_push;
        nrow_root.child[0] = r_left;
        nrow_root.child[1] = r_right;
    end

    // memory port steering
    always_comb begin
        leaf_we    = 1'b0;
        leaf_waddr = r_cur;
        leaf_wrow  = lrow_place;
        node_we    = 1'b0;
        node_waddr = r_pv;
        node_wrow  = nrow_place;
        leaf_raddr = r_cur;
        node_raddr = (i_cmd.code == bpt_ins_pkg::CMD_UP_RD) ?
                     r_walk[d_m1[bpt_ins_pkg::WALK_AW-1:0]] : r_cur[bpt_ins_pkg::NODE_AW-1:0];
        case (i_cmd.code)
            bpt_ins_pkg::CMD_CREATE: begin
                leaf_we         = 1'b1;
                leaf_waddr      = r_leaves_used[bpt_ins_pkg::LEAF_AW-1:0];
                leaf_wrow       = '0;
                leaf_wrow.right = bpt_ins_pkg::LEAF_NONE;
            end
            bpt_ins_pkg::CMD_LEAF_PLACE: begin
                leaf_we = 1'b1;
            end
            bpt_ins_pkg::CMD_LEAF_SPLIT: begin
                leaf_we   = 1'b1;
                leaf_wrow = lrow_left;
            end
            bpt_ins_pkg::CMD_WRITE2: begin
                leaf_we    = r_pend_is_leaf;
                leaf_waddr = r_pend_addr[bpt_ins_pkg::LEAF_AW-1:0];
                leaf_wrow  = r_pend_leaf;
                node_we    = !r_pend_is_leaf;
                node_waddr = r_pend_addr[bpt_ins_pkg::NODE_AW-1:0];
                node_wrow  = r_pend_node;
            end
            bpt_ins_pkg::CMD_NEW_ROOT: begin
                node_we    = 1'b1;
                node_waddr = r_nodes_used[bpt_ins_pkg::NODE_AW-1:0];
                node_wrow  = nrow_root;
            end
            bpt_ins_pkg::CMD_UP_PLACE: begin
                node_we = 1'b1;
            end
            bpt_ins_pkg::CMD_UP_SPLIT: begin
                node_we   = 1'b1;
                node_wrow = nrow_left;
            end
            default: begin
            end
        endcase
    end

    bpt_ins_ram #(.WIDTH(LROW_W), .DEPTH(bpt_ins_pkg::LEAF_NODES)) u_leaf_ram (
        .i_clk   (i_clk),
        .i_we    (leaf_we),
        .i_waddr (leaf_waddr),
        .i_wdata (LROW_W'(leaf_wrow)),
        .i_raddr (leaf_raddr),
        .o_rdata (leaf_rdata)
    );

    bpt_ins_ram #(.WIDTH(NROW_W), .DEPTH(bpt_ins_pkg::INTERNAL_NODES)) u_node_ram (
        .i_clk   (i_clk),
        .i_we    (node_we),
        .i_waddr (node_waddr),
        .i_wdata (NROW_W'(node_wrow)),
        .i_raddr (node_raddr),
        .o_rdata (node_rdata)
    );

    // a split climbs through the run of full nodes directly above the leaf; all full adds a root
    assign need      = r_run + ((r_run == r_depth) ? 1'b1 : 1'b0);
    assign nodes_sum = {1'b0, r_nodes_used} + 8'(need);

    always_comb begin
        o_stat.is_create      = (r_item.opcode == bpt_ins_pkg::OP_CREATE);
        o_stat.attr_ok        = ({1'b0, r_item.attribute_index} < 5'(bpt_ins_pkg::ATTRIBUTES));
        o_stat.present        = r_present[r_item.attribute_index];
        o_stat.leaf_pool_full = (r_leaves_used >= 8'(bpt_ins_pkg::LEAF_NODES));
        o_stat.is_leaf        = r_isleaf;
        o_stat.leaf_full      = (lq.fill >= 2'(bpt_ins_pkg::LEAF_KEYS));
        o_stat.split_ok       = (r_leaves_used < 8'(bpt_ins_pkg::LEAF_NODES)) &&
                                (nodes_sum <= 8'(bpt_ins_pkg::INTERNAL_NODES));
        o_stat.d_zero         = (r_d == '0);
        o_stat.node_full      = (nq.fill >= 3'(bpt_ins_pkg::NODE_KEYS));
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < bpt_ins_pkg::ATTRIBUTES; a++) begin
                r_present[a] <= 1'b0;
            end
            r_leaves_used <= '0;
            r_nodes_used  <= '0;
            r_done        <= 1'b0;
        end else begin
            r_done <= (i_cmd.code == bpt_ins_pkg::CMD_REPORT_OK) ||
                      (i_cmd.code == bpt_ins_pkg::CMD_REPORT_ERR);
            case (i_cmd.code)
                bpt_ins_pkg::CMD_CREATE: begin
                    r_present[r_item.attribute_index] <= 1'b1;
                    r_leaves_used <= r_leaves_used + 1'b1;
                end
                bpt_ins_pkg::CMD_LEAF_SPLIT: begin
                    r_leaves_used <= r_leaves_used + 1'b1;
                end
                bpt_ins_pkg::CMD_NEW_ROOT, bpt_ins_pkg::CMD_UP_SPLIT: begin
                    r_nodes_used <= r_nodes_used + 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        case (i_cmd.code)
            bpt_ins_pkg::CMD_ACCEPT: begin
                r_item <= i_item;
            end
            bpt_ins_pkg::CMD_CREATE: begin
                r_root[r_item.attribute_index]  <= r_leaves_used[6:0];
                r_rleaf[r_item.attribute_index] <= 1'b1;
                r_holder <= r_leaves_used[6:0];
            end
            bpt_ins_pkg::CMD_WALK_INIT: begin
                r_cur    <= r_root[r_item.attribute_index];
                r_isleaf <= r_rleaf[r_item.attribute_index];
                r_depth  <= '0;
                r_run    <= '0;
            end
            bpt_ins_pkg::CMD_NODE_STEP: begin
                r_walk[r_depth[bpt_ins_pkg::WALK_AW-1:0]] <= r_cur[bpt_ins_pkg::NODE_AW-1:0];
                r_depth  <= r_depth + 1'b1;
                r_run    <= (nq.fill >= 3'(bpt_ins_pkg::NODE_KEYS)) ? r_run + 1'b1 : '0;
                r_cur    <= wchild[6:0];
                r_isleaf <= wchild[7];
            end
            bpt_ins_pkg::CMD_LEAF_PLACE: begin
                r_holder <= r_cur;
            end
            bpt_ins_pkg::CMD_LEAF_SPLIT: begin
                r_holder       <= (lp < 2'(bpt_ins_pkg::HALF)) ? r_cur : r_leaves_used[6:0];
                r_push         <= lk[bpt_ins_pkg::HALF - 1];
                r_left         <= {1'b1, r_cur};
                r_right        <= {1'b1, r_leaves_used[6:0]};
                r_d            <= r_depth;
                r_pend_leaf    <= lrow_right;
                r_pend_addr    <= r_leaves_used[6:0];
                r_pend_is_leaf <= 1'b1;
            end
            bpt_ins_pkg::CMD_NEW_ROOT: begin
                r_root[r_item.attribute_index]  <= r_nodes_used;
                r_rleaf[r_item.attribute_index] <= 1'b0;
            end
            bpt_ins_pkg::CMD_UP_RD: begin
                r_pv <= r_walk[d_m1[bpt_ins_pkg::WALK_AW-1:0]];
            end
            bpt_ins_pkg::CMD_UP_SPLIT: begin
                r_push         <= tk[bpt_ins_pkg::HALF];
                r_left         <= {2'b00, r_pv};
                r_right        <= {1'b0, r_nodes_used};
                r_d            <= d_m1;
                r_pend_node    <= nrow_right;
                r_pend_addr    <= r_nodes_used;
                r_pend_is_leaf <= 1'b0;
            end
            bpt_ins_pkg::CMD_REPORT_OK: begin
                r_result.status       <= bpt_ins_pkg::ST_OK;
                r_result.leaf_node    <= r_holder;
                r_result.root_node    <= r_root[r_item.attribute_index];
                r_result.root_is_leaf <= r_rleaf[r_item.attribute_index];
            end
            bpt_ins_pkg::CMD_REPORT_ERR: begin
                r_result.status    <= i_cmd.status;
                r_result.leaf_node <= '0;
                if ((i_cmd.status == bpt_ins_pkg::ST_EXISTS) ||
                    ((i_cmd.status == bpt_ins_pkg::ST_FULL) &&
                     (r_item.opcode == bpt_ins_pkg::OP_INSERT))) begin
                    r_result.root_node    <= r_root[r_item.attribute_index];
                    r_result.root_is_leaf <= r_rleaf[r_item.attribute_index];
                end else begin
                    r_result.root_node    <= '0;
                    r_result.root_is_leaf <= 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_done   = r_done;
    assign o_result = r_result;

    `BPT_ASSERT_ALWAYS(a_leaf_pool_bound, i_clk, i_rst_n, r_leaves_used <= 8'(bpt_ins_pkg::LEAF_NODES), "leaf pool overrun")
    `BPT_ASSERT_ALWAYS(a_node_pool_bound, i_clk, i_rst_n, r_nodes_used <= 7'(bpt_ins_pkg::INTERNAL_NODES), "internal pool overrun")
    `BPT_ASSERT_NEXT(a_done_single, i_clk, i_rst_n, r_done, !r_done, "result strobe held for two cycles")

endmodule

@@ rtl/bplus_tree_insert_engine.sv @@
// Channel  | Direction | Handshake                     | Payload
// ---------+-----------+-------------------------------+----------------------
// command  | in        | beat taken when start & !busy | i_item   (t_item)
// result   | out       | one-cycle strobe o_done       | o_result (t_result)
//
// Steps, command beat to result: a create decodes and writes the new leaf, then reports;
// an insert decodes, then per internal level reads the node row and picks the child,
// then reads the leaf row, places or splits, reports and strobes. Each split adds a
// second row write, then a parent row read or a new root write; placing writes the parent.
// Reset: synchronous, active low; clears index flags and pool counts, no sweep.
// Stalls: the receiver cannot stall; busy holds commands off while an item runs.
module bplus_tree_insert_engine (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  bpt_ins_pkg::t_item   i_item,
    output logic                 o_done,
    output bpt_ins_pkg::t_result o_result
);

    bpt_ins_pkg::t_cmd  cmd;
    bpt_ins_pkg::t_stat stat;

    // sequence the walk down and the split climb
    bpt_ins_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    // hold the index table, node memories and the result register
    bpt_ins_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_cmd    (cmd),
        .o_stat   (stat),
        .o_done   (o_done),
        .o_result (o_result)
    );

endmodule
